// ----- rtl/ppfl_pkg.sv -----
// Package for the per-CPU page free list: sizes, codes and shared types.
// No dependencies; every other file of the block imports it.
package ppfl_pkg;

    localparam int CPU_COUNT  = 8;
    localparam int POOL_PAGES = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int CPU_W      = $clog2(CPU_COUNT);
    localparam int SLOT_W     = $clog2(POOL_PAGES);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = 32;
    localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;

    localparam int FIRST_W    = 20;
    localparam int LIMIT_W    = 21;
    localparam int ALU_W      = LIMIT_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_NO_MEM   = 2'd2
    } status_t;

    typedef enum logic {
        ACT_FREE  = 1'b0,
        ACT_ALLOC = 1'b1
    } action_t;

    typedef enum logic {
        CFG_IDX_FIRST = 1'b0,
        CFG_IDX_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_FREE_LO,
        SEQ_FREE_HI,
        SEQ_ALLOC_SEL,
        SEQ_ALLOC_RD,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        slot_t addr;
        link_t wdata;
    } mem_req_t;

endpackage

// ----- rtl/ppfl_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on ppfl_pkg for field widths.
interface ppfl_req_if;
    import ppfl_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [2:0]          requester_cpu;
    logic [ADDR_W-1:0]   page_address;

    modport source (output valid, output action, output requester_cpu,
                    output page_address, input ready);
    modport sink   (input valid, input action, input requester_cpu,
                    input page_address, output ready);
endinterface

interface ppfl_rsp_if;
    import ppfl_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   granted_address;

    modport source (output valid, output status, output granted_address, input ready);
    modport sink   (input valid, input status, input granted_address, output ready);
endinterface

// ----- rtl/ppfl_cfg_regs.sv -----
// APB-style register file holding first_page and limit_page.
// Depends on ppfl_pkg.
module ppfl_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppfl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ppfl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ppfl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [ppfl_pkg::FIRST_W-1:0]    first_page,
    output logic [ppfl_pkg::LIMIT_W-1:0]    limit_page
);
    import ppfl_pkg::*;

    logic [FIRST_W-1:0] first_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               wr_en;
    cfg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    // Word addressing: the byte offset bits are ignored
    assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            limit_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                CFG_IDX_FIRST: first_reg <= pwdata[FIRST_W-1:0];
                CFG_IDX_LIMIT: limit_reg <= pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            CFG_IDX_FIRST: prdata = CFG_DATA_W'(first_reg);
            CFG_IDX_LIMIT: prdata = CFG_DATA_W'(limit_reg);
        endcase
    end

    assign first_page = first_reg;
    assign limit_page = limit_reg;

endmodule

// ----- rtl/ppfl_alu.sv -----
// Shared add/subtract unit used by the sequencer for range checks and
// address forming. Depends on ppfl_pkg.
module ppfl_alu (
    input  ppfl_pkg::alu_op_t            op,
    input  logic [ppfl_pkg::ALU_W-1:0]   a,
    input  logic [ppfl_pkg::ALU_W-1:0]   b,
    output logic [ppfl_pkg::ALU_W:0]     res
);
    import ppfl_pkg::*;

    // Top bit is the carry on add and the borrow on subtract
    always_comb
    begin
        unique case (op)
            ALU_ADD: res = {1'b0, a} + {1'b0, b};
            ALU_SUB: res = {1'b0, a} - {1'b0, b};
        endcase
    end

endmodule

// ----- rtl/ppfl_link_ram.sv -----
// Next-link memory: one entry per pool slot, registered read.
// Depends on ppfl_pkg. Contents are undefined until written.
module ppfl_link_ram (
    input  logic                clk,
    input  ppfl_pkg::mem_req_t  req,
    output ppfl_pkg::link_t     rdata
);
    import ppfl_pkg::*;

    link_t mem [POOL_PAGES];
    link_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ppfl_seq.sv -----
// Sequencer: list heads, request decoding, ALU and memory steps, result register.
// Depends on ppfl_pkg; drives ppfl_alu and ppfl_link_ram.
module ppfl_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ppfl_pkg::FIRST_W-1:0]    first_page,
    input  logic [ppfl_pkg::LIMIT_W-1:0]    limit_page,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_action,
    input  logic [2:0]                      in_cpu,
    input  logic [ppfl_pkg::ADDR_W-1:0]     in_addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ppfl_pkg::status_t               out_status,
    output logic [ppfl_pkg::ADDR_W-1:0]     out_granted,
    output ppfl_pkg::alu_op_t               alu_op,
    output logic [ppfl_pkg::ALU_W-1:0]      alu_a,
    output logic [ppfl_pkg::ALU_W-1:0]      alu_b,
    input  logic [ppfl_pkg::ALU_W:0]        alu_res,
    output ppfl_pkg::mem_req_t              mem_req,
    input  ppfl_pkg::link_t                 mem_rdata
);
    import ppfl_pkg::*;

    seq_state_t              state_reg, state_next;
    logic [CPU_W-1:0]        cpu_reg;
    logic [CPU_W-1:0]        src_reg;
    logic [PAGE_NUM_W-1:0]   page_reg;
    logic                    misaligned_reg;
    slot_t                   slot_reg;
    status_t                 status_reg;
    logic [ADDR_W-1:0]       granted_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [ADDR_W-1:0]       out_granted_reg;
    slot_t                   head_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0]    nonempty_reg;

    logic                    accept;
    logic                    src_found;
    logic [CPU_W-1:0]        src_idx;
    logic                    borrow;
    logic [ALU_W-1:0]        diff;
    logic                    lo_bad;
    logic                    hi_bad;
    logic                    out_load;

    assign accept   = in_valid && in_ready;
    assign borrow   = alu_res[ALU_W];
    assign diff     = alu_res[ALU_W-1:0];
    assign lo_bad   = misaligned_reg || borrow || (diff >= ALU_W'(POOL_PAGES));
    // page >= limit leaves no borrow
    assign hi_bad   = !borrow;
    assign out_load = (state_reg == SEQ_FINISH) && (!out_valid_reg || out_ready);

    // Own list first, else the lowest-numbered nonempty list
    always_comb
    begin
        src_found = 1'b0;
        src_idx   = cpu_reg;
        if (nonempty_reg[cpu_reg])
        begin
            src_found = 1'b1;
        end
        else
        begin
            for (int c = CPU_COUNT - 1; c >= 0; c--)
            begin
                if (nonempty_reg[c])
                begin
                    src_found = 1'b1;
                    src_idx   = CPU_W'(c);
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action_t'(in_action) == ACT_ALLOC) ? SEQ_ALLOC_SEL
                                                                     : SEQ_FREE_LO;
                end
            end
            SEQ_FREE_LO:   state_next = lo_bad ? SEQ_FINISH : SEQ_FREE_HI;
            SEQ_FREE_HI:   state_next = SEQ_FINISH;
            SEQ_ALLOC_SEL: state_next = src_found ? SEQ_ALLOC_RD : SEQ_FINISH;
            SEQ_ALLOC_RD:  state_next = SEQ_FINISH;
            SEQ_FINISH:
            begin
                if (out_load)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:       state_next = SEQ_IDLE;
        endcase
    end

    // Outputs to the shared unit and the link memory
    always_comb
    begin
        in_ready      = 1'b0;
        alu_op        = ALU_ADD;
        alu_a         = '0;
        alu_b         = '0;
        mem_req.wr_en = 1'b0;
        mem_req.rd_en = 1'b0;
        mem_req.addr  = slot_reg;
        mem_req.wdata = '0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
            end
            SEQ_FREE_LO:
            begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(page_reg);
                alu_b  = ALU_W'(first_page);
            end
            SEQ_FREE_HI:
            begin
                alu_op        = ALU_SUB;
                alu_a         = ALU_W'(page_reg);
                alu_b         = ALU_W'(limit_page);
                mem_req.wr_en = !hi_bad;
                mem_req.wdata = nonempty_reg[cpu_reg]
                              ? LINK_W'(head_reg[cpu_reg]) + LINK_W'(1) : '0;
            end
            SEQ_ALLOC_SEL:
            begin
                mem_req.rd_en = src_found;
                mem_req.addr  = head_reg[src_idx];
            end
            SEQ_ALLOC_RD:
            begin
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(first_page);
                alu_b  = ALU_W'(slot_reg);
            end
            SEQ_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
            nonempty_reg  <= '0;
            for (int c = 0; c < CPU_COUNT; c++)
            begin
                head_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Push on a good free
            if (state_reg == SEQ_FREE_HI && !hi_bad)
            begin
                head_reg[cpu_reg]     <= slot_reg;
                nonempty_reg[cpu_reg] <= 1'b1;
            end

            // Pop: advance the head to the link just read
            if (state_reg == SEQ_ALLOC_RD)
            begin
                if (mem_rdata == '0)
                begin
                    nonempty_reg[src_reg] <= 1'b0;
                    head_reg[src_reg]     <= '0;
                end
                else
                begin
                    head_reg[src_reg] <= SLOT_W'(mem_rdata - LINK_W'(1));
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cpu_reg        <= CPU_W'(in_cpu % CPU_COUNT);
            page_reg       <= in_addr[ADDR_W-1:PAGE_SHIFT];
            misaligned_reg <= |in_addr[PAGE_SHIFT-1:0];
        end

        unique case (state_reg)
            SEQ_FREE_LO:
            begin
                slot_reg    <= diff[SLOT_W-1:0];
                status_reg  <= ST_BAD_ADDR;
                granted_reg <= '0;
            end
            SEQ_FREE_HI:
            begin
                status_reg <= hi_bad ? ST_BAD_ADDR : ST_OK;
            end
            SEQ_ALLOC_SEL:
            begin
                src_reg     <= src_idx;
                slot_reg    <= head_reg[src_idx];
                status_reg  <= ST_NO_MEM;
                granted_reg <= '0;
            end
            SEQ_ALLOC_RD:
            begin
                status_reg  <= ST_OK;
                granted_reg <= ADDR_W'(alu_res) << PAGE_SHIFT;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_status_reg  <= status_reg;
            out_granted_reg <= granted_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_granted = out_granted_reg;

endmodule

// ----- rtl/per_cpu_page_free_list.sv -----
// Per-CPU page free list. Keeps a pool of up to 32768 pages of 4 KiB as one
// LIFO list per CPU (8 CPUs), linked through an on-chip next-link RAM. A free
// transaction checks the address (page aligned, within first_page..limit_page
// and the pool) and pushes it on the requester's list, or answers bad address
// with no change. An alloc transaction pops the requester's list, or the
// lowest-numbered nonempty list when its own is empty, or answers out of
// memory. Lists are empty after reset; the link RAM needs no clearing pass.
// The response register is loaded when the sequencer is done, sooner for a free
// that fails the lower range check and for out of memory. A small sequencer runs
// the two range checks, or the list pick, the registered link RAM read and the
// address add, through one shared add/subtract unit. The next request is taken
// the cycle after the load, so transactions are handled one at a time, and a
// finished response waits in the sequencer while the response register is full.
// A new request is taken once the sequencer is back in idle, even while the last
// response still waits to be taken.
module per_cpu_page_free_list (
    input  logic                            clk,
    input  logic                            rst_n,
    ppfl_req_if.sink                        req,
    ppfl_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppfl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ppfl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ppfl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ppfl_pkg::*;

    logic [FIRST_W-1:0] first_page;
    logic [LIMIT_W-1:0] limit_page;
    alu_op_t            alu_op;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic [ALU_W:0]     alu_res;
    mem_req_t           mem_req;
    link_t              mem_rdata;
    status_t            out_status;

    ppfl_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .first_page (first_page),
        .limit_page (limit_page)
    );

    ppfl_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    ppfl_link_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    ppfl_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .first_page  (first_page),
        .limit_page  (limit_page),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_action   (req.action),
        .in_cpu      (req.requester_cpu),
        .in_addr     (req.page_address),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_status  (out_status),
        .out_granted (rsp.granted_address),
        .alu_op      (alu_op),
        .alu_a       (alu_a),
        .alu_b       (alu_b),
        .alu_res     (alu_res),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    assign rsp.status = out_status;

endmodule

// ----- sim/per_cpu_page_free_list_tb.sv -----
`timescale 1ns / 1ps
// Testbench for per_cpu_page_free_list: directed table, then random free/alloc traffic
// checked against a behavioral copy of the per-CPU lists. Needs ppfl_pkg, ppfl_if and the RTL.
module per_cpu_page_free_list_tb;
    import ppfl_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int ITEMS_PER_WINDOW = 112;
    localparam int SCRIPT_ROWS      = 28;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] address;
    } grant_t;

    typedef enum logic {
        ROW_REQ    = 1'b0,
        ROW_WINDOW = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        action_t            act;
        logic [2:0]         cpu;
        logic [ADDR_W-1:0]  addr;
        logic               typed;
        grant_t             known;
        logic [FIRST_W-1:0] win_lo;
        logic [LIMIT_W-1:0] win_hi;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    ppfl_req_if req_ch ();
    ppfl_rsp_if rsp_ch ();

    per_cpu_page_free_list dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the allocator state
    slot_t              cpu_head      [CPU_COUNT];
    logic               cpu_has_pages [CPU_COUNT];
    link_t              slot_link     [POOL_PAGES];
    logic [FIRST_W-1:0] win_first;
    logic [LIMIT_W-1:0] win_limit;

    grant_t      pending_grants [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic grant_t apply_page_request(action_t act, logic [2:0] cpu,
                                                  logic [ADDR_W-1:0] addr);
        grant_t      g;
        int unsigned who;
        int unsigned page;
        int          src;
        int          c;
        slot_t       slot;
        link_t       nx;
        g.status  = ST_OK;
        g.address = '0;
        who = int'(cpu) % CPU_COUNT;
        if (act == ACT_FREE)
        begin
            page = addr >> PAGE_SHIFT;
            if (addr[PAGE_SHIFT-1:0] != '0 || page < win_first || page >= win_limit
                || page - win_first >= POOL_PAGES)
                g.status = ST_BAD_ADDR;
            else
            begin
                slot = slot_t'(page - win_first);
                slot_link[slot] = cpu_has_pages[who] ? link_t'(cpu_head[who]) + link_t'(1) : '0;
                cpu_head[who]      = slot;
                cpu_has_pages[who] = 1'b1;
            end
        end
        else
        begin
            // Own list first, else steal from the lowest-numbered CPU holding a page
            src = -1;
            if (cpu_has_pages[who])
                src = who;
            else
                for (c = 0; c < CPU_COUNT; c++)
                    if (src < 0 && c != who && cpu_has_pages[c])
                        src = c;
            if (src < 0)
                g.status = ST_NO_MEM;
            else
            begin
                slot = cpu_head[src];
                nx   = slot_link[slot];
                if (nx == '0)
                begin
                    cpu_has_pages[src] = 1'b0;
                    cpu_head[src]      = '0;
                end
                else
                    cpu_head[src] = slot_t'(nx - link_t'(1));
                g.address = 32'((64'(win_first) + 64'(slot)) * PAGE_BYTES);
            end
        end
        return g;
    endfunction

    function automatic script_row_t item_row(action_t act, logic [2:0] cpu,
                                             logic [ADDR_W-1:0] addr);
        script_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.act   = act;
        r.cpu   = cpu;
        r.addr  = addr;
        return r;
    endfunction

    function automatic script_row_t known_row(action_t act, logic [2:0] cpu,
                                              logic [ADDR_W-1:0] addr, status_t st,
                                              logic [ADDR_W-1:0] granted);
        script_row_t r;
        r               = item_row(act, cpu, addr);
        r.typed         = 1'b1;
        r.known.status  = st;
        r.known.address = granted;
        return r;
    endfunction

    function automatic script_row_t window_row(logic [FIRST_W-1:0] lo, logic [LIMIT_W-1:0] hi);
        script_row_t r;
        r        = '0;
        r.kind   = ROW_WINDOW;
        r.win_lo = lo;
        r.win_hi = hi;
        return r;
    endfunction

    task automatic send_page_request(action_t act, logic [2:0] cpu, logic [ADDR_W-1:0] addr,
                                     logic typed, grant_t known);
        grant_t g;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.requester_cpu <= cpu;
        req_ch.page_address  <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        g = apply_page_request(act, cpu, addr);
        pending_grants.push_back(typed ? known : g);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_transfer(logic wr, cfg_idx_t idx, logic [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(int'(idx) * 4);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
    endtask

    task automatic program_window(logic [FIRST_W-1:0] first, logic [LIMIT_W-1:0] limit);
        logic [CFG_DATA_W-1:0] rd;
        apb_transfer(1'b1, CFG_IDX_FIRST, CFG_DATA_W'(first), rd);
        apb_transfer(1'b1, CFG_IDX_LIMIT, CFG_DATA_W'(limit), rd);
        apb_transfer(1'b0, CFG_IDX_FIRST, '0, rd);
        if (rd[FIRST_W-1:0] !== first)
        begin
            $error("first_page: expected %h, actual %h", first, rd[FIRST_W-1:0]);
            mismatches++;
        end
        apb_transfer(1'b0, CFG_IDX_LIMIT, '0, rd);
        if (rd[LIMIT_W-1:0] !== limit)
        begin
            $error("limit_page: expected %h, actual %h", limit, rd[LIMIT_W-1:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        win_first = first;
        win_limit = limit;
    endtask

    // Response side: check each transaction, then pick the next ready level
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("unexpected response: status %0d, granted_address %h",
                       rsp_ch.status, rsp_ch.granted_address);
                mismatches++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.granted_address !== want.address)
                begin
                    $error("granted_address: expected %h, actual %h",
                           want.address, rsp_ch.granted_address);
                    mismatches++;
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    initial
    begin
        script_row_t        script [SCRIPT_ROWS];
        int unsigned        src_modes  [3];
        int unsigned        sink_modes [3];
        logic [FIRST_W-1:0] rand_lo [4];
        logic [LIMIT_W-1:0] rand_hi [4];
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        pick;
        int unsigned        alloc_pct;
        action_t            act;
        logic [2:0]         cpu;
        logic [ADDR_W-1:0]  addr;

        src_modes  = '{22, 70, 0};
        sink_modes = '{70, 22, 0};
        rand_lo    = '{20'h00040, 20'h00000, 20'h12345, 20'hFFF00};
        rand_hi    = '{21'h000080, 21'h100000, 21'h01B345, 21'h100000};

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.action        = ACT_FREE;
        req_ch.requester_cpu = '0;
        req_ch.page_address  = '0;
        win_first            = '0;
        win_limit            = '0;
        alloc_pct            = 50;
        for (int c = 0; c < CPU_COUNT; c++)
        begin
            cpu_head[c]      = '0;
            cpu_has_pages[c] = 1'b0;
        end

        script = '{
            // reset window is empty: nothing can be freed or allocated
            known_row(ACT_FREE,  3'd0, 32'h0000_0000, ST_BAD_ADDR, 32'h0),
            known_row(ACT_ALLOC, 3'd5, 32'hFFFF_FFFF, ST_NO_MEM,   32'h0),
            window_row(20'h00010, 21'h000030),
            known_row(ACT_FREE,  3'd0, 32'h0001_0000, ST_OK,       32'h0),
            known_row(ACT_FREE,  3'd7, 32'h0002_F000, ST_OK,       32'h0),
            known_row(ACT_FREE,  3'd3, 32'h0003_0000, ST_BAD_ADDR, 32'h0),
            known_row(ACT_FREE,  3'd3, 32'h0000_F000, ST_BAD_ADDR, 32'h0),
            known_row(ACT_FREE,  3'd3, 32'h0001_0800, ST_BAD_ADDR, 32'h0),
            known_row(ACT_FREE,  3'd3, 32'hFFFF_FFFF, ST_BAD_ADDR, 32'h0),
            // double free hands the same page out twice
            known_row(ACT_FREE,  3'd2, 32'h0001_1000, ST_OK,       32'h0),
            known_row(ACT_FREE,  3'd2, 32'h0001_1000, ST_OK,       32'h0),
            known_row(ACT_ALLOC, 3'd2, 32'h0,         ST_OK,       32'h0001_1000),
            known_row(ACT_ALLOC, 3'd2, 32'h0,         ST_OK,       32'h0001_1000),
            known_row(ACT_ALLOC, 3'd4, 32'h0,         ST_OK,       32'h0001_0000),
            // move the window with a page still listed on cpu 7
            window_row(20'hFFFFF, 21'h100000),
            item_row(ACT_ALLOC,  3'd4, 32'h0),
            known_row(ACT_FREE,  3'd6, 32'hFFFF_F000, ST_OK,       32'h0),
            known_row(ACT_FREE,  3'd6, 32'hFFFF_E000, ST_BAD_ADDR, 32'h0),
            known_row(ACT_ALLOC, 3'd6, 32'h0,         ST_OK,       32'hFFFF_F000),
            item_row(ACT_ALLOC,  3'd1, 32'h0),
            window_row(20'h00000, 21'h100000),
            known_row(ACT_FREE,  3'd1, 32'h07FF_F000, ST_OK,       32'h0),
            known_row(ACT_FREE,  3'd1, 32'h0800_0000, ST_BAD_ADDR, 32'h0),
            known_row(ACT_FREE,  3'd5, 32'h0000_0000, ST_OK,       32'h0),
            known_row(ACT_ALLOC, 3'd1, 32'h0,         ST_OK,       32'h07FF_F000),
            item_row(ACT_ALLOC,  3'd3, 32'h0),
            // limit below first: every free is rejected
            window_row(20'hFFFFF, 21'h000000),
            known_row(ACT_FREE,  3'd0, 32'hFFFF_F000, ST_BAD_ADDR, 32'h0)
        };

        src_idle_pct  = src_modes[0];
        sink_idle_pct = sink_modes[0];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WINDOW)
            begin
                drain_responses();
                program_window(script[i].win_lo, script[i].win_hi);
            end
            else
                send_page_request(script[i].act, script[i].cpu, script[i].addr,
                                  script[i].typed, script[i].known);
        end

        for (int m = 0; m < 3; m++)
        begin
            src_idle_pct  = src_modes[m];
            sink_idle_pct = sink_modes[m];
            for (int w = 0; w < 4; w++)
            begin
                drain_responses();
                program_window(rand_lo[w], rand_hi[w]);
                for (int n = 0; n < ITEMS_PER_WINDOW; n++)
                begin
                    // shift the alloc/free mix so lists both fill up and run dry
                    if (n % 40 == 0)
                        alloc_pct = $urandom_range(25, 75);
                    cpu  = 3'($urandom_range(0, 7));
                    addr = $urandom;
                    if ($urandom_range(0, 99) < alloc_pct)
                        act = ACT_ALLOC;
                    else
                    begin
                        act = ACT_FREE;
                        lo  = win_first;
                        hi  = win_limit;
                        if (hi > lo + POOL_PAGES)
                            hi = lo + POOL_PAGES;
                        pick = $urandom_range(0, 99);
                        if (hi > lo && pick < 80)
                            addr = 32'($urandom_range(lo, hi - 1)) << PAGE_SHIFT;
                        else if (hi > lo && pick < 87)
                            addr = (32'($urandom_range(lo, hi - 1)) << PAGE_SHIFT)
                                   | 32'($urandom_range(1, PAGE_BYTES - 1));
                        else if (lo > 0 && pick < 92)
                            addr = 32'($urandom_range(0, lo - 1)) << PAGE_SHIFT;
                        else if (hi < 32'h10_0000 && pick < 97)
                            addr = 32'($urandom_range(hi, 32'hF_FFFF)) << PAGE_SHIFT;
                    end
                    send_page_request(act, cpu, addr, 1'b0, '0);
                end
            end
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
